[sv/sorted_expiry_timer_table_unit_assert.svh]
// Assertion macros for the sorted expiry timer table unit.
// Depends on nothing; included by the top level.
`ifndef SORTED_EXPIRY_TIMER_TABLE_UNIT_ASSERT_SVH
`define SORTED_EXPIRY_TIMER_TABLE_UNIT_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define SETT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Plain invariant.
`define SETT_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

`endif

[sv/sett_pkg.sv]
// Package for the sorted expiry timer table unit: types, codes and sizes.
// Depends on nothing.
package sett_pkg;

  localparam int Depth = 16;
  localparam int IdxW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_TICK   = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DELETED   = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_EXPIRED   = 3'd4,
    ST_NONE_EXP  = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] timer_id;
    logic [30:0] duration;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] expired_id;
    logic [4:0]  entries_left;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [15:0] id;
    logic [31:0] start;
    logic [30:0] dur;
  } slot_t;

endpackage

[sv/sett_table.sv]
// Slot storage for the timer table: one write port and one registered read port.
// Depends on sett_pkg.
module sett_table (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [sett_pkg::IdxW-1:0] waddr_i,
  input  sett_pkg::slot_t     wdata_i,
  input  logic [sett_pkg::IdxW-1:0] raddr_i,
  output sett_pkg::slot_t     rdata_o
);
  import sett_pkg::*;

  slot_t mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[sv/sorted_expiry_timer_table_unit.sv]
// Sorted expiry timer table: insert, delete by id and tick expiry, one slot per cycle.
// The final result follows the walk; a full insert is answered in the next cycle without a walk.
// A new command is taken only when idle; busy is high during the walk.
// Results show for one cycle on res_valid_o; the receiver cannot stall.
// Asynchronous active-low reset empties the table and clears the tick count.
// Depends on sett_pkg, sett_table and sorted_expiry_timer_table_unit_assert.svh.
`include "sorted_expiry_timer_table_unit_assert.svh"
module sorted_expiry_timer_table_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  sett_pkg::cmd_t cmd_i,
  output logic           res_valid_o,
  output sett_pkg::res_t res_o
);
  import sett_pkg::*;

  state_e state_q, state_d;
  cmd_t   cmd_q, cmd_d;
  logic [31:0]   now_q, now_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] rd_q, rd_d;   // read pointer
  logic [CntW-1:0] wr_q, wr_d;   // compaction write pointer
  logic          done_q, done_d; // insert placed / delete found / tick has a held result
  slot_t         carry_q, carry_d; // insert: entry waiting to be written
  res_t          pend_q, pend_d;   // tick: expired result held back one step
  logic          res_valid_d;
  res_t          res_d, res_q;
  logic          res_valid_q;
  logic          we;
  logic [IdxW-1:0] waddr;
  slot_t         wdata, rdata;
  logic [31:0]   elapsed;
  logic          at_end;

  // read data is registered, so the next pointer addresses the table
  sett_table u_table (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(rd_d[IdxW-1:0]),
    .rdata_o(rdata)
  );

  assign elapsed = now_q - rdata.start;
  assign at_end  = (rd_q == cnt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      now_q       <= '0;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      now_q       <= now_d;
      cnt_q       <= cnt_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    rd_q    <= rd_d;
    wr_q    <= wr_d;
    done_q  <= done_d;
    carry_q <= carry_d;
    pend_q  <= pend_d;
    res_q   <= res_d;
  end

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    now_d       = now_q;
    cnt_d       = cnt_q;
    rd_d        = rd_q;
    wr_d        = wr_q;
    done_d      = done_q;
    carry_d     = carry_q;
    pend_d      = pend_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    we          = 1'b0;
    waddr       = wr_q[IdxW-1:0];
    wdata       = rdata;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_d   = cmd_i;
          rd_d    = '0;
          wr_d    = '0;
          done_d  = 1'b0;
          carry_d = '{id: cmd_i.timer_id, start: now_q, dur: cmd_i.duration};
          unique case (op_e'(cmd_i.operation))
            OP_INSERT: begin
              if (cnt_q == CntW'(Depth)) begin
                res_valid_d = 1'b1;
                res_d = '{status: ST_FULL, expired_id: '0,
                          entries_left: 5'(cnt_q), last: 1'b1};
              end else begin
                state_d = S_SCAN;
              end
            end
            OP_DELETE: state_d = S_SCAN;
            OP_TICK: begin
              now_d   = now_q + 32'd1;
              state_d = S_SCAN;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        unique case (op_e'(cmd_q.operation))
          OP_INSERT: begin
            // ripple: each slot is replaced by the carried entry once the
            // insert point is passed, carrying the old slot forward
            we    = 1'b1;
            waddr = rd_q[IdxW-1:0];
            if (at_end) begin
              wdata   = carry_q;
              cnt_d   = cnt_q + 1'b1;
              state_d = S_DONE;
              res_d   = '{status: ST_INSERTED, expired_id: '0,
                          entries_left: 5'(cnt_q + 1'b1), last: 1'b1};
            end else if (done_q || rdata.dur >= carry_q.dur) begin
              wdata   = carry_q;
              carry_d = rdata;
              done_d  = 1'b1;
              rd_d    = rd_q + 1'b1;
            end else begin
              rd_d = rd_q + 1'b1;
            end
          end
          OP_DELETE: begin
            if (at_end) begin
              state_d = S_DONE;
              if (done_q) begin
                cnt_d = cnt_q - 1'b1;
                res_d = '{status: ST_DELETED, expired_id: '0,
                          entries_left: 5'(cnt_q - 1'b1), last: 1'b1};
              end else begin
                res_d = '{status: ST_NOT_FOUND, expired_id: '0,
                          entries_left: 5'(cnt_q), last: 1'b1};
              end
            end else begin
              if (!done_q && rdata.id == cmd_q.timer_id) begin
                done_d = 1'b1;
              end else begin
                we   = 1'b1;
                wr_d = wr_q + 1'b1;
              end
              rd_d = rd_q + 1'b1;
            end
          end
          default: begin
            // tick: compact survivors; each expired result waits for the next
            // one so that the final one can carry last
            if (at_end) begin
              cnt_d   = wr_q;
              state_d = S_DONE;
              if (done_q) begin
                res_d      = pend_q;
                res_d.last = 1'b1;
              end else begin
                res_d = '{status: ST_NONE_EXP, expired_id: '0,
                          entries_left: 5'(wr_q), last: 1'b1};
              end
            end else begin
              rd_d = rd_q + 1'b1;
              if (elapsed > {1'b0, rdata.dur}) begin
                done_d = 1'b1;
                pend_d = '{status: ST_EXPIRED, expired_id: rdata.id,
                           entries_left: 5'(cnt_q - rd_q + wr_q - 1'b1),
                           last: 1'b0};
                if (done_q) begin
                  res_valid_d = 1'b1;
                  res_d       = pend_q;
                end
              end else begin
                we   = 1'b1;
                wr_d = wr_q + 1'b1;
              end
            end
          end
        endcase
      end
      default: begin
        // S_DONE: send the final result
        state_d     = S_IDLE;
        res_valid_d = 1'b1;
      end
    endcase
  end

  assign busy        = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  `SETT_ASSERT_ALWAYS(a_cnt_range, clk_i, rst_ni, cnt_q <= CntW'(Depth))
  `SETT_ASSERT_IMPL(a_idle_on_start, clk_i, rst_ni, start && !busy, state_q == S_IDLE)
  `SETT_ASSERT_IMPL(a_tick_adv, clk_i, rst_ni,
    start && !busy && cmd_i.operation == OP_TICK, ##1 now_q == $past(now_q) + 32'd1)

endmodule
